### hdl/pprt_pkg.sv
`timescale 1ns / 1ps

package pprt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int ID_W    = 32;
  localparam int ADDR_W  = 32;
  localparam int PLEN_W  = 6;
  localparam int REQ_W   = 2;
  localparam int VERD_W  = 2;
  localparam int CNT32_W = 32;
  localparam int ENT_W   = ID_W + ADDR_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 2'd0,
    REQ_DROP    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef enum logic [VERD_W-1:0] {
    VERD_ACCEPT = 2'd0,
    VERD_DROP   = 2'd1,
    VERD_DONE   = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_SEEK,
    ST_EMIT_LOAD,
    ST_COMPACT,
    ST_DONE
  } seq_state_t;

  // one result beat as handed from the sequencer to the output register
  typedef struct packed {
    logic [ID_W-1:0]    verdict_id;
    verdict_t           verdict;
    logic               last;
    logic               table_empty;
    logic               push_rejected;
    logic [CNT32_W-1:0] dropped_total;
  } res_t;

endpackage

### hdl/pprt_if.sv
`timescale 1ns / 1ps

interface pprt_in_if import pprt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   packet_id;
  logic [ADDR_W-1:0] dest_addr;
  logic [PLEN_W-1:0] prefix_len;

  modport source (output valid, req_type, packet_id, dest_addr, prefix_len, input ready);
  modport sink   (input valid, req_type, packet_id, dest_addr, prefix_len, output ready);
endinterface

interface pprt_out_if import pprt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    verdict_id;
  logic [VERD_W-1:0]  verdict;
  logic               last;
  logic               table_empty;
  logic               push_rejected;
  logic [CNT32_W-1:0] dropped_total;

  modport source (output valid, verdict_id, verdict, last, table_empty, push_rejected,
                  dropped_total, input ready);
  modport sink   (input valid, verdict_id, verdict, last, table_empty, push_rejected,
                  dropped_total, output ready);
endinterface

### hdl/pending_packet_release_table_core.sv
`timescale 1ns / 1ps
// push: the done beat goes from the done state through the output register
// drop/release: the done beat follows three passes over the entry memory
//   (match, emit, compact)
// throughput: one request at a time, in_ch.ready is high only between requests
// reset (rst_n low, synchronous): table empty, drop count zero, output empty;
//   entry memory contents are not cleared

module pending_packet_release_table_core import pprt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pprt_in_if.sink    in_ch,
  pprt_out_if.source out_ch
);

  logic res_vld;
  logic res_rdy;
  res_t res;
  res_t out_r;
  logic out_valid_r;

  pprt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .res     (res)
  );

  // output register decouples the sequencer from the result sink
  assign res_rdy = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict_id    = out_r.verdict_id;
  assign out_ch.verdict       = out_r.verdict;
  assign out_ch.last          = out_r.last;
  assign out_ch.table_empty   = out_r.table_empty;
  assign out_ch.push_rejected = out_r.push_rejected;
  assign out_ch.dropped_total = out_r.dropped_total;

  // a taken request beat always starts work, so the next cycle is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a request beat");

  // a waiting result beat stays offered until the output register takes it
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_rdy |=> res_vld)
    else $error("result beat withdrawn before it was taken");

  // no result beat is offered while the block waits for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !res_vld)
    else $error("result beat offered while idle");

endmodule

### hdl/pprt_ram.sv
`timescale 1ns / 1ps

module pprt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read port that holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/pprt_seq.sv
`timescale 1ns / 1ps

module pprt_seq import pprt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pprt_in_if.sink    in_ch,
  output logic       res_vld,
  input  logic       res_rdy,
  output res_t       res
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  seq_state_t         st_r, st_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      keep_r, keep_nxt;
  logic [CW-1:0]      m_r, m_nxt;
  logic [CNT32_W-1:0] drop_r, drop_nxt;
  logic               rej_r, rej_nxt;
  logic               is_drop_r, is_drop_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  mask_r, mask_nxt;
  logic [TABLE_DEPTH-1:0] match_r, match_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;
  logic               hit;
  logic               more;
  logic [CW-1:0]      prev_idx;

  // entries kept oldest first at positions 0 .. count-1
  pprt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare unit: masked destination match on the entry just read
  assign hit      = ((rd_data[ADDR_W-1:0] ^ addr_r) & mask_r) == '0;
  assign more     = idx_r < n_r;
  assign prev_idx = idx_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      drop_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    keep_r    <= keep_nxt;
    m_r       <= m_nxt;
    rej_r     <= rej_nxt;
    is_drop_r <= is_drop_nxt;
    addr_r    <= addr_nxt;
    mask_r    <= mask_nxt;
    match_r   <= match_nxt;
    rd_idx_r  <= rd_idx_nxt;
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    m_nxt       = m_r;
    drop_nxt    = drop_r;
    rej_nxt     = rej_r;
    is_drop_nxt = is_drop_r;
    addr_nxt    = addr_r;
    mask_nxt    = mask_r;
    match_nxt   = match_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;

    rd_en   = 1'b0;
    rd_addr = idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = keep_r[IW-1:0];
    wr_data = rd_data;

    in_ch.ready = (st_r == ST_IDLE);

    res_vld           = 1'b0;
    res.verdict_id    = rd_data[ENT_W-1:ADDR_W];
    res.verdict       = is_drop_r ? VERD_DROP : VERD_ACCEPT;
    res.last          = 1'b0;
    res.table_empty   = (cnt_r == '0);
    res.push_rejected = 1'b0;
    res.dropped_total = drop_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          rej_nxt = 1'b0;
          unique case (in_ch.req_type)
            REQ_PUSH: begin
              if (cnt_r >= CW'(TABLE_DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[IW-1:0];
                wr_data = {in_ch.packet_id, in_ch.dest_addr};
                cnt_nxt = cnt_r + CW'(1);
              end
              st_nxt = ST_DONE;
            end
            REQ_DROP, REQ_RELEASE: begin
              is_drop_nxt = (in_ch.req_type == REQ_DROP);
              addr_nxt    = in_ch.dest_addr;
              // lengths of 32 and above shift everything out: full mask
              mask_nxt    = (in_ch.req_type == REQ_DROP) ? '1 :
                            ~({ADDR_W{1'b1}} >> in_ch.prefix_len);
              n_nxt       = cnt_r;
              idx_nxt     = '0;
              m_nxt       = '0;
              match_nxt   = '0;
              st_nxt      = ST_SCAN;
            end
            default: begin
              st_nxt = ST_DONE;
            end
          endcase
        end
      end

      // pass one: mark matches and count them, read pipelined one deep
      ST_SCAN: begin
        if (more) begin
          rd_en      = 1'b1;
          idx_nxt    = idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[IW-1:0];
        end
        if (rd_vld_r && hit) begin
          match_nxt[rd_idx_r] = 1'b1;
          m_nxt               = m_r + CW'(1);
        end
        if (!more && !rd_vld_r) begin
          cnt_nxt = cnt_r - m_r;
          if (is_drop_r) begin
            drop_nxt = drop_r + CNT32_W'(m_r);
          end
          idx_nxt = n_r;
          st_nxt  = ST_EMIT_SEEK;
        end
      end

      // pass two: newest first, fetch each matched entry
      ST_EMIT_SEEK: begin
        if (idx_r == '0) begin
          keep_nxt = '0;
          st_nxt   = ST_COMPACT;
        end else begin
          idx_nxt = prev_idx;
          if (match_r[prev_idx[IW-1:0]]) begin
            rd_en   = 1'b1;
            rd_addr = prev_idx[IW-1:0];
            st_nxt  = ST_EMIT_LOAD;
          end
        end
      end

      ST_EMIT_LOAD: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          st_nxt = ST_EMIT_SEEK;
        end
      end

      // pass three: move survivors down, oldest first
      ST_COMPACT: begin
        if (more) begin
          idx_nxt = idx_r + CW'(1);
          if (!match_r[idx_r[IW-1:0]]) begin
            rd_en      = 1'b1;
            rd_vld_nxt = 1'b1;
          end
        end
        if (rd_vld_r) begin
          wr_en    = 1'b1;
          keep_nxt = keep_r + CW'(1);
        end
        if (!more && !rd_vld_r) begin
          st_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        res_vld           = 1'b1;
        res.verdict_id    = '0;
        res.verdict       = VERD_DONE;
        res.last          = 1'b1;
        res.push_rejected = rej_r;
        if (res_rdy) begin
          st_nxt = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### tb/pending_packet_release_table_core_tb.sv
`timescale 1ns / 1ps

module pending_packet_release_table_core_tb;
  import pprt_pkg::*;

  localparam int TBL_DEPTH    = 32;
  localparam int RAND_ITEMS   = 210;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int POOL_N       = 6;
  localparam int MAX_PRINTS   = 60;

  // request code outside the defined set, must only yield a done beat
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // one request beat, with an optional hand-written done beat
  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [ID_W-1:0]    pid;
    logic [ADDR_W-1:0]  dest;
    logic [PLEN_W-1:0]  plen;
    bit                 typed;
    bit                 t_empty;
    bit                 t_rej;
    logic [CNT32_W-1:0] t_drops;
  } req_item_t;

  // directed row: reps > 1 repeats a push with id + n and dest + (n & 3)
  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [ID_W-1:0]    pid;
    logic [ADDR_W-1:0]  dest;
    logic [PLEN_W-1:0]  plen;
    int                 reps;
    bit                 typed;
    bit                 t_empty;
    bit                 t_rej;
    logic [CNT32_W-1:0] t_drops;
  } dir_row_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] dest;
  } held_pkt_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pprt_in_if  in_if ();
  pprt_out_if out_if ();

  pending_packet_release_table_core #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed requests
  dir_row_t dir_tab [20] = '{
    // drop and release on the empty table right after reset
    '{REQ_DROP,    32'h0000_0000, 32'h0000_0000, 6'd0,  1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'h0000_0000, 6'd0,  1, 1'b1, 1'b1, 1'b0, 32'd0},
    // field extremes on push
    '{REQ_PUSH,    32'h0000_0000, 32'h0000_0000, 6'd0,  1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{REQ_PUSH,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{REQ_PUSH,    32'h1234_5678, 32'hC0A8_0101, 6'd5,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_PUSH,    32'hA5A5_A5A5, 32'hC0A8_01FE, 6'd16, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_PUSH,    32'h5A5A_5A5A, 32'hC0A9_0000, 6'd32, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    // exact drop, /16 release, prefix length above 32
    '{REQ_DROP,    32'h0BAD_F00D, 32'hFFFF_FFFF, 6'd0,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'hC0A8_0000, 6'd16, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'hC0A9_0000, 6'd63, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    // unknown request leaves the table alone, the zero-id packet is still held
    '{REQ_UNKNOWN, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0,  1, 1'b1, 1'b0, 1'b0, 32'd1},
    // zero prefix releases everything
    '{REQ_PUSH,    32'h0000_0001, 32'h0A00_0001, 6'd0,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    // fill the table, then one push too many
    '{REQ_PUSH,    32'h8000_0000, 32'h0A0B_0C00, 6'd0, 32, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_PUSH,    32'hDEAD_BEEF, 32'h0000_0000, 6'd0,  1, 1'b1, 1'b0, 1'b1, 32'd1},
    // drain a full table by several matches per request, but the /1 release matches none
    '{REQ_DROP,    32'h0000_0000, 32'h0A0B_0C01, 6'd0,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'h8000_0000, 6'd1,  1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'h0A0B_0C02, 6'd32, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_RELEASE, 32'h0000_0000, 32'h0A0B_0C00, 6'd30, 1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{REQ_DROP,    32'hFFFF_FFFF, 32'h0000_0000, 6'd63, 1, 1'b1, 1'b1, 1'b0, 32'd9}
  };

  req_item_t stim_q[$];
  res_t      verdict_q[$];

  // predicted table contents, oldest first
  held_pkt_t          held_q[$];
  logic [CNT32_W-1:0] drop_cnt = '0;

  int err_cnt    = 0;
  int acc_cnt    = 0;
  int stim_total = 0;

  function automatic logic [ADDR_W-1:0] route_mask(logic [PLEN_W-1:0] plen);
    if (plen == 0) return '0;
    if (plen >= 32) return '1;
    return 32'hFFFF_FFFF << (32 - plen);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("%0t ns: mismatch on %s, got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // update the table image for one request and queue the beats it causes
  task automatic predict_request(input req_item_t it);
    logic [ADDR_W-1:0] mask;
    logic [ID_W-1:0]   hit_ids[$];
    bit                rejected;
    res_t              beat;
    int                k;
    rejected = 1'b0;
    mask     = '1;
    if (it.req == REQ_PUSH) begin
      if (held_q.size() >= TBL_DEPTH) rejected = 1'b1;
      else held_q.push_back({it.pid, it.dest});
    end else if (it.req == REQ_DROP || it.req == REQ_RELEASE) begin
      if (it.req == REQ_RELEASE) mask = route_mask(it.plen);
      // newest first
      for (k = held_q.size() - 1; k >= 0; k--) begin
        if (((held_q[k].dest ^ it.dest) & mask) == '0) begin
          hit_ids.push_back(held_q[k].id);
          held_q.delete(k);
          if (it.req == REQ_DROP) drop_cnt = drop_cnt + 1'b1;
        end
      end
    end

    if (it.typed) begin
      beat.verdict_id    = '0;
      beat.verdict       = VERD_DONE;
      beat.last          = 1'b1;
      beat.table_empty   = it.t_empty;
      beat.push_rejected = it.t_rej;
      beat.dropped_total = it.t_drops;
      verdict_q.push_back(beat);
    end else begin
      foreach (hit_ids[i]) begin
        beat.verdict_id    = hit_ids[i];
        beat.verdict       = (it.req == REQ_DROP) ? VERD_DROP : VERD_ACCEPT;
        beat.last          = 1'b0;
        beat.table_empty   = (held_q.size() == 0);
        beat.push_rejected = 1'b0;
        beat.dropped_total = drop_cnt;
        verdict_q.push_back(beat);
      end
      beat.verdict_id    = '0;
      beat.verdict       = VERD_DONE;
      beat.last          = 1'b1;
      beat.table_empty   = (held_q.size() == 0);
      beat.push_rejected = rejected;
      beat.dropped_total = drop_cnt;
      verdict_q.push_back(beat);
    end
  endtask

  // build the whole request list: directed rows, then random sequences
  initial begin : gen_stimulus
    logic [ADDR_W-1:0] pool [POOL_N];
    logic [ADDR_W-1:0] recent[$];
    logic [ADDR_W-1:0] lowm;
    req_item_t         it;
    int                n_rand;
    int                n;
    int                r;
    int                sel;
    foreach (dir_tab[i]) begin
      for (r = 0; r < dir_tab[i].reps; r++) begin
        it.req     = dir_tab[i].req;
        it.pid     = dir_tab[i].pid + 32'(r);
        it.dest    = dir_tab[i].dest + 32'(r & 3);
        it.plen    = dir_tab[i].plen;
        it.typed   = dir_tab[i].typed;
        it.t_empty = dir_tab[i].t_empty;
        it.t_rej   = dir_tab[i].t_rej;
        it.t_drops = dir_tab[i].t_drops;
        stim_q.push_back(it);
      end
    end

    foreach (pool[i]) pool[i] = $urandom;
    it.typed   = 1'b0;
    it.t_empty = 1'b0;
    it.t_rej   = 1'b0;
    it.t_drops = '0;
    n_rand     = 0;
    while (n_rand < RAND_ITEMS) begin
      sel     = $urandom_range(0, 19);
      it.pid  = $urandom;
      it.plen = 6'($urandom);
      case ($urandom_range(0, 3))
        0:       lowm = 32'h0000_00FF;
        1:       lowm = 32'h0000_FFFF;
        default: lowm = '0;
      endcase
      if (sel < 8) begin
        // push run, now and then long enough to fill the table
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
        for (r = 0; r < n; r++) begin
          it.req  = REQ_PUSH;
          it.pid  = $urandom;
          it.dest = pool[$urandom_range(0, POOL_N - 1)] ^ ($urandom & lowm);
          recent.push_back(it.dest);
          if (recent.size() > 16) void'(recent.pop_front());
          stim_q.push_back(it);
        end
        n_rand += n;
      end else if (sel < 12) begin
        // drop, mostly of a destination pushed lately
        it.req = REQ_DROP;
        if (recent.size() != 0 && $urandom_range(0, 4) != 0)
          it.dest = recent[$urandom_range(0, recent.size() - 1)];
        else
          it.dest = $urandom;
        stim_q.push_back(it);
        n_rand++;
      end else if (sel < 17) begin
        // release around a pool address
        it.req  = REQ_RELEASE;
        it.dest = pool[$urandom_range(0, POOL_N - 1)] ^ ($urandom & lowm);
        if ($urandom_range(0, 3) != 0) it.plen = 6'($urandom_range(8, 32));
        stim_q.push_back(it);
        n_rand++;
      end else begin
        // noise, unknown request code included
        it.req  = REQ_W'($urandom);
        it.dest = $urandom;
        stim_q.push_back(it);
        n_rand++;
        pool[$urandom_range(0, POOL_N - 1)] = $urandom;
      end
    end
    stim_total = stim_q.size();
  end

  // request sender: bursts of beats with random gaps
  req_item_t cur_req;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.req_type   <= '0;
      in_if.packet_id  <= '0;
      in_if.dest_addr  <= '0;
      in_if.prefix_len <= '0;
    end else begin
      next_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_request(cur_req);
        acc_cnt++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          cur_req            = stim_q.pop_front();
          in_if.req_type    <= cur_req.req;
          in_if.packet_id   <= cur_req.pid;
          in_if.dest_addr   <= cur_req.dest;
          in_if.prefix_len  <= cur_req.plen;
          next_valid         = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              2:       gap_left = $urandom_range(4, 12);
              default: gap_left = $urandom_range(0, 30);
            endcase
          end
        end
      end
      in_if.valid <= next_valid;
    end
  end

  // result receiver: always ready, a rotating stall pattern, or random stalls
  int unsigned rdy_mode = 0;
  int unsigned rdy_left = 0;
  logic [7:0]  rdy_pat  = 8'h01;

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(16, 96);
      rdy_pat  = 8'($urandom) | 8'h01;
    end
    rdy_left--;
    rdy_pat = {rdy_pat[6:0], rdy_pat[7]};
    case (rdy_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= rdy_pat[0];
      default: out_if.ready <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected beat, verdict_id", out_if.verdict_id, '0);
      end else begin
        want = verdict_q.pop_front();
        if (out_if.verdict_id !== want.verdict_id)
          report_mismatch("verdict_id", out_if.verdict_id, want.verdict_id);
        if (out_if.verdict !== want.verdict)
          report_mismatch("verdict", 32'(out_if.verdict), 32'(want.verdict));
        if (out_if.last !== want.last)
          report_mismatch("last", 32'(out_if.last), 32'(want.last));
        if (out_if.table_empty !== want.table_empty)
          report_mismatch("table_empty", 32'(out_if.table_empty), 32'(want.table_empty));
        if (out_if.push_rejected !== want.push_rejected)
          report_mismatch("push_rejected", 32'(out_if.push_rejected),
                          32'(want.push_rejected));
        if (out_if.dropped_total !== want.dropped_total)
          report_mismatch("dropped_total", out_if.dropped_total, want.dropped_total);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int idle_cyc = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc + 1 >= IDLE_LIMIT) begin
      $display("pending_packet_release_table_core_tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // reset, run until every request is taken and drained, final verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (acc_cnt < stim_total || verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch("missing beats, count", 32'(verdict_q.size()), '0);
    if (err_cnt == 0) begin
      $display("pending_packet_release_table_core_tb: clean");
    end else begin
      $display("pending_packet_release_table_core_tb: errors");
    end
    $finish;
  end

endmodule
